// ===== design/rsabc_pkg.sv =====
`timescale 1ns / 1ps

package rsabc_pkg;

    localparam int MOD_W     = 31;
    localparam int WORD_W    = 32;
    localparam int MUL_STEPS = 32;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] REG_ENC_EXP = 2'd0;
    localparam logic [1:0] REG_ENC_MOD = 2'd1;
    localparam logic [1:0] REG_DEC_EXP = 2'd2;
    localparam logic [1:0] REG_DEC_MOD = 2'd3;

    localparam logic [WORD_W-1:0] RST_ENC_EXP = 32'd7;
    localparam logic [MOD_W-1:0]  RST_ENC_MOD = 31'd95477;
    localparam logic [WORD_W-1:0] RST_DEC_EXP = 32'd38291;
    localparam logic [MOD_W-1:0]  RST_DEC_MOD = 31'd84823;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_ACC  = 5'b00100,
        S_SQR  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // One shift-and-add step: (2*p + (b ? x : 0)) mod md, with p, x below md.
    function automatic logic [MOD_W-1:0] mod_step(
        input logic [MOD_W-1:0] p,
        input logic [MOD_W-1:0] x,
        input logic             b,
        input logic [MOD_W-1:0] md
    );
        logic [MOD_W+1:0] t;
        logic [MOD_W+1:0] md1;
        logic [MOD_W+1:0] md2;
        logic [MOD_W+1:0] r;
        t   = {1'b0, p, 1'b0} + (b ? {2'b00, x} : '0);
        md1 = {2'b00, md};
        md2 = {1'b0, md, 1'b0};
        if (t >= md2) begin
            r = t - md2;
        end else if (t >= md1) begin
            r = t - md1;
        end else begin
            r = t;
        end
        return r[MOD_W-1:0];
    endfunction

endpackage

// ===== design/rsa_byte_cipher.sv =====
`timescale 1ns / 1ps

// Byte-wide textbook RSA engine. Pulse start while busy is low to transfer an
// encrypt (plain byte) or decrypt (cipher word) request; busy stays high until
// the last result has been shown. Each result appears on o_result_word and
// o_last for exactly one cycle with o_valid high; the receiver cannot stall
// it, so it must sample every strobe. An encrypt request for a carriage
// return gives two results, CR then LF, the second with o_last set. All
// arithmetic runs through one shift-and-add modular multiplier that handles
// one multiplier bit per cycle. One result first reduces the base, then for
// each of WORD_BITS exponent bits multiplies the result by the square when
// the bit is set and squares it, then shows the result. A modulus below two
// skips the arithmetic and returns 0 in the cycle after the request is taken.
// Configuration writes are taken at once and must only occur while idle.
module rsa_byte_cipher #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_plain_byte,
    input  logic [31:0] i_cipher_word,
    output logic        o_valid,
    output logic [31:0] o_result_word,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int MW    = rsabc_pkg::MOD_W;
    localparam int WW    = rsabc_pkg::WORD_W;
    localparam int SW    = rsabc_pkg::STEP_W;

    rsabc_pkg::t_state r_state, n_state;

    logic [WW-1:0]    r_enc_exp, r_dec_exp;
    logic [MW-1:0]    r_enc_mod, r_dec_mod;

    logic             r_mode, n_mode;
    logic             r_pend, n_pend;
    logic [WW-1:0]    r_exp, n_exp;
    logic [MW-1:0]    r_md, n_md;
    logic [MW-1:0]    r_acc, n_acc;
    logic [MW-1:0]    r_sq, n_sq;
    logic [MW-1:0]    r_prod, n_prod;
    logic [MW-1:0]    r_x, n_x;
    logic [WW-1:0]    r_y, n_y;
    logic [SW-1:0]    r_cnt, n_cnt;
    logic [BIT_W-1:0] r_bit, n_bit;

    logic             ld_go;
    logic             ld_mode;
    logic [WW-1:0]    ld_base;
    logic [MW-1:0]    ld_md;
    logic [MW-1:0]    prod_next;
    logic             mul_end;

    assign prod_next = rsabc_pkg::mod_step(r_prod, r_x, r_y[WW-1], r_md);
    assign mul_end   = (r_cnt == SW'(rsabc_pkg::MUL_STEPS - 1));

    assign busy          = (r_state != rsabc_pkg::S_IDLE);
    assign o_valid       = (r_state == rsabc_pkg::S_DONE);
    assign o_last        = !r_pend;
    assign o_result_word = r_mode ? {24'd0, r_acc[7:0]} : {1'b0, r_acc};

    always_comb begin
        ld_go   = 1'b0;
        ld_mode = r_mode;
        ld_base = {24'd0, rsabc_pkg::CHAR_LF};
        if (r_state == rsabc_pkg::S_IDLE) begin
            ld_go   = start;
            ld_mode = i_req_type;
            if (i_req_type) begin
                ld_base = i_cipher_word;
            end else begin
                ld_base = {24'd0, i_plain_byte};
            end
        end else if (r_state == rsabc_pkg::S_DONE) begin
            ld_go = r_pend;
        end
        ld_md = ld_mode ? r_dec_mod : r_enc_mod;
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_exp   = r_exp;
        n_md    = r_md;
        n_acc   = r_acc;
        n_sq    = r_sq;
        n_prod  = r_prod;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_bit   = r_bit;

        if (r_state == rsabc_pkg::S_ACC || r_state == rsabc_pkg::S_SQR ||
            r_state == rsabc_pkg::S_RED) begin
            n_prod = prod_next;
            n_y    = r_y << 1;
            n_cnt  = r_cnt + SW'(1);
        end

        unique case (r_state)
            rsabc_pkg::S_IDLE: begin
            end
            rsabc_pkg::S_RED: begin
                if (mul_end) begin
                    n_sq   = prod_next;
                    n_acc  = MW'(1);
                    n_bit  = '0;
                    n_prod = '0;
                    n_cnt  = '0;
                    n_y    = {1'b0, prod_next};
                    if (r_exp[0]) begin
                        n_state = rsabc_pkg::S_ACC;
                        n_x     = MW'(1);
                    end else begin
                        n_state = rsabc_pkg::S_SQR;
                        n_x     = prod_next;
                    end
                end
            end
            rsabc_pkg::S_ACC: begin
                if (mul_end) begin
                    n_acc   = prod_next;
                    n_state = rsabc_pkg::S_SQR;
                    n_x     = r_sq;
                    n_y     = {1'b0, r_sq};
                    n_prod  = '0;
                    n_cnt   = '0;
                end
            end
            rsabc_pkg::S_SQR: begin
                if (mul_end) begin
                    n_sq   = prod_next;
                    n_exp  = r_exp >> 1;
                    n_bit  = r_bit + BIT_W'(1);
                    n_prod = '0;
                    n_cnt  = '0;
                    n_y    = {1'b0, prod_next};
                    if (r_bit == BIT_W'(WORD_BITS - 1)) begin
                        n_state = rsabc_pkg::S_DONE;
                    end else if (r_exp[1]) begin
                        n_state = rsabc_pkg::S_ACC;
                        n_x     = r_acc;
                    end else begin
                        n_state = rsabc_pkg::S_SQR;
                        n_x     = prod_next;
                    end
                end
            end
            rsabc_pkg::S_DONE: begin
                n_state = rsabc_pkg::S_IDLE;
                n_pend  = 1'b0;
            end
            default: begin
                n_state = rsabc_pkg::S_IDLE;
            end
        endcase

        if (ld_go) begin
            n_mode = ld_mode;
            n_md   = ld_md;
            n_exp  = ld_mode ? r_dec_exp : r_enc_exp;
            n_x    = MW'(1);
            n_y    = ld_base;
            n_prod = '0;
            n_cnt  = '0;
            if (r_state == rsabc_pkg::S_IDLE) begin
                n_pend = !i_req_type && (i_plain_byte == rsabc_pkg::CHAR_CR);
                if (!i_req_type && (i_plain_byte == rsabc_pkg::CHAR_CR)) begin
                    n_y = {24'd0, rsabc_pkg::CHAR_CR};
                end
            end else begin
                n_pend = 1'b0;
            end
            if (ld_md[MW-1:1] == '0) begin
                n_acc   = '0;
                n_state = rsabc_pkg::S_DONE;
            end else begin
                n_state = rsabc_pkg::S_RED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsabc_pkg::S_IDLE;
            r_pend    <= 1'b0;
            r_enc_exp <= rsabc_pkg::RST_ENC_EXP;
            r_enc_mod <= rsabc_pkg::RST_ENC_MOD;
            r_dec_exp <= rsabc_pkg::RST_DEC_EXP;
            r_dec_mod <= rsabc_pkg::RST_DEC_MOD;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rsabc_pkg::REG_ENC_EXP: r_enc_exp <= i_cfg_data;
                    rsabc_pkg::REG_ENC_MOD: r_enc_mod <= i_cfg_data[MW-1:0];
                    rsabc_pkg::REG_DEC_EXP: r_dec_exp <= i_cfg_data;
                    rsabc_pkg::REG_DEC_MOD: r_dec_mod <= i_cfg_data[MW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_exp  <= n_exp;
        r_md   <= n_md;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_prod <= n_prod;
        r_x    <= n_x;
        r_y    <= n_y;
        r_cnt  <= n_cnt;
        r_bit  <= n_bit;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

class rsa_tracker;
    logic [31:0] enc_exp;
    logic [30:0] enc_mod;
    logic [31:0] dec_exp;
    logic [30:0] dec_mod;
    logic [31:0] pending_words[$];
    logic        pending_last[$];
    int          errors;

    function new();
        enc_exp = rsabc_pkg::RST_ENC_EXP;
        enc_mod = rsabc_pkg::RST_ENC_MOD;
        dec_exp = rsabc_pkg::RST_DEC_EXP;
        dec_mod = rsabc_pkg::RST_DEC_MOD;
        errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            rsabc_pkg::REG_ENC_EXP: enc_exp = data;
            rsabc_pkg::REG_ENC_MOD: enc_mod = data[30:0];
            rsabc_pkg::REG_DEC_EXP: dec_exp = data;
            rsabc_pkg::REG_DEC_MOD: dec_mod = data[30:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] pow_mod(logic [31:0] base, logic [31:0] expo, logic [30:0] md);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned m;
        if (md < 31'd2) begin
            return 32'd0;
        end
        m   = {33'd0, md};
        acc = 1;
        sq  = base % m;
        for (int i = 0; i < 32; i++) begin
            if (expo[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[31:0];
    endfunction

    function void note(logic kind, logic [7:0] ch, logic [31:0] word);
        logic [31:0] plain;
        if (kind == 1'b1) begin
            plain = pow_mod(word, dec_exp, dec_mod);
            pending_words.push_back({24'd0, plain[7:0]});
            pending_last.push_back(1'b1);
        end else if (ch == rsabc_pkg::CHAR_CR) begin
            pending_words.push_back(pow_mod({24'd0, rsabc_pkg::CHAR_CR}, enc_exp, enc_mod));
            pending_last.push_back(1'b0);
            pending_words.push_back(pow_mod({24'd0, rsabc_pkg::CHAR_LF}, enc_exp, enc_mod));
            pending_last.push_back(1'b1);
        end else begin
            pending_words.push_back(pow_mod({24'd0, ch}, enc_exp, enc_mod));
            pending_last.push_back(1'b1);
        end
    endfunction

    function void check(logic [31:0] word, logic last);
        logic [31:0] exp_word;
        logic        exp_last;
        if (pending_words.size() == 0) begin
            $error("unexpected result: result_word %h last %b", word, last);
            errors++;
            return;
        end
        exp_word = pending_words.pop_front();
        exp_last = pending_last.pop_front();
        if (word !== exp_word) begin
            $error("result_word: expected %h, got %h", exp_word, word);
            errors++;
        end
        if (last !== exp_last) begin
            $error("last: expected %b, got %b", exp_last, last);
            errors++;
        end
    endfunction

    function int pending();
        return pending_words.size();
    endfunction
endclass

module testbench;

    localparam int  EXP_BITS     = 32;
    localparam int  LIMIT_CYCLES = 6_000_000;
    localparam int  TAIL_CYCLES  = 2200;
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        i_req_type    = 1'b0;
    logic [7:0]  i_plain_byte  = 8'd0;
    logic [31:0] i_cipher_word = 32'd0;
    logic        o_valid;
    logic [31:0] o_result_word;
    logic        o_last;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = 2'd0;
    logic [31:0] i_cfg_data    = 32'd0;

    int          cycles = 0;
    rsa_tracker  tracker;

    rsa_byte_cipher #(
        .WORD_BITS(EXP_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_plain_byte (i_plain_byte),
        .i_cipher_word(i_cipher_word),
        .o_valid      (o_valid),
        .o_result_word(o_result_word),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            tracker.check(o_result_word, o_last);
        end
    end

    task automatic send_req(input logic kind, input logic [7:0] ch, input logic [31:0] word);
        start         <= 1'b1;
        i_req_type    <= kind;
        i_plain_byte  <= ch;
        i_cipher_word <= word;
        do @(posedge i_clk); while (busy);
        tracker.note(kind, ch, word);
    endtask

    task automatic pause_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 4);
        end else begin
            gap = $urandom_range(20, 400);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0 || busy);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic apply_config(input logic [31:0] ee, input logic [31:0] em,
                                input logic [31:0] de, input logic [31:0] dm);
        write_reg(rsabc_pkg::REG_ENC_EXP, ee);
        write_reg(rsabc_pkg::REG_ENC_MOD, em);
        write_reg(rsabc_pkg::REG_DEC_EXP, de);
        write_reg(rsabc_pkg::REG_DEC_MOD, dm);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        logic [30:0] md;
        case ($urandom_range(0, 5))
            0: md = 31'd2 + 31'($urandom_range(0, 20));
            1: md = 31'h7FFF_FFFF - 31'($urandom_range(0, 100));
            2: md = 31'($urandom_range(2, 65535));
            default: md = 31'($urandom_range(2, 32'h7FFF_FFFF));
        endcase
        return {1'($urandom_range(0, 1)), md};
    endfunction

    task automatic random_req();
        logic       kind;
        logic [7:0] ch;
        kind = 1'($urandom_range(0, 1));
        ch   = ($urandom_range(0, 7) == 0) ? rsabc_pkg::CHAR_CR : 8'($urandom);
        send_req(kind, ch, $urandom);
    endtask

    initial begin
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of all registers
        send_req(REQ_ENCRYPT, 8'h00, $urandom);
        send_req(REQ_ENCRYPT, 8'hFF, $urandom);
        pause_sender();
        send_req(REQ_ENCRYPT, rsabc_pkg::CHAR_CR, $urandom);
        send_req(REQ_ENCRYPT, rsabc_pkg::CHAR_LF, $urandom);
        send_req(REQ_ENCRYPT, 8'h80, 32'hFFFF_FFFF);
        send_req(REQ_DECRYPT, 8'hFF, 32'h0000_0000);
        send_req(REQ_DECRYPT, 8'h00, 32'hFFFF_FFFF);
        pause_sender();
        send_req(REQ_DECRYPT, 8'($urandom), 32'd84822);
        send_req(REQ_DECRYPT, 8'($urandom), 32'd84823);
        send_req(REQ_DECRYPT, 8'($urandom), 32'h8000_0000);
        drain();

        // exponent zero and the smallest modulus on encrypt, widest values on decrypt
        apply_config(32'd0, 32'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_req(REQ_ENCRYPT, rsabc_pkg::CHAR_CR, $urandom);
        send_req(REQ_ENCRYPT, 8'h00, $urandom);
        send_req(REQ_DECRYPT, 8'($urandom), 32'hFFFF_FFFF);
        send_req(REQ_DECRYPT, 8'($urandom), 32'h7FFF_FFFE);
        drain();

        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0002);
        send_req(REQ_ENCRYPT, 8'hFF, $urandom);
        send_req(REQ_ENCRYPT, rsabc_pkg::CHAR_CR, $urandom);
        send_req(REQ_DECRYPT, 8'($urandom), 32'd0);
        send_req(REQ_DECRYPT, 8'($urandom), 32'd5);
        drain();

        // modulus below two
        apply_config(32'd0, 32'h8000_0001, 32'h1234_5678, 32'd0);
        send_req(REQ_ENCRYPT, rsabc_pkg::CHAR_CR, $urandom);
        send_req(REQ_DECRYPT, 8'($urandom), 32'h1234_5678);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            apply_config(pick_exponent(), pick_modulus(), pick_exponent(), pick_modulus());
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(0, 24) == 0) begin
                    drain();
                end
                random_req();
                if ($urandom_range(0, 4) != 0) begin
                    pause_sender();
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/rsabc_pkg.sv
design/rsa_byte_cipher.sv
tb/testbench.sv
